// ----- design/optt_pkg.sv -----
// optt_pkg: shared types and constants for the oneshot / periodic timer table
// table geometry, operation and result codes, sequencer states, entry record
// used by optt_unit and oneshot_periodic_timer_table
`default_nettype none

package optt_pkg;

  // number of timer slots in the table
  localparam int SLOTS = 16;
  // slot index width and width of a count that can reach SLOTS
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  // field widths of the item
  localparam int KEY_W  = 16;
  localparam int TMO_W  = 31;
  localparam int TIME_W = 32;
  localparam int MCNT_W = 5;

  // operation codes on in_tuser
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_DEL  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // result kinds on out_tuser
  localparam logic [2:0] KIND_ADDED   = 3'd0;
  localparam logic [2:0] KIND_FULL    = 3'd1;
  localparam logic [2:0] KIND_DELETED = 3'd2;
  localparam logic [2:0] KIND_FIRED   = 3'd3;
  localparam logic [2:0] KIND_QUIET   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_DEL,
    ST_FIRE,
    ST_FLUSH,
    ST_PACK
  } state_t;

  // one timer slot
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TMO_W-1:0]  timeout;
    logic [TIME_W-1:0] last_fired;
    logic              repeat_en;
    logic              marked;
  } entry_t;

  // verdict of the shared compare unit on one slot
  typedef struct packed {
    logic expired;
    logic key_hit;
  } verdict_t;

endpackage

`default_nettype wire

// ----- design/oneshot_periodic_timer_table.sv -----
// oneshot_periodic_timer_table: top level of the software timer table
// holds the slot array, the sequencer and the output register; uses optt_pkg, optt_unit
`default_nettype none

// A table of SLOTS timers, each with a key, a timeout, a repeat flag and a
// last-fired stamp. An item on the input stream carries an operation in
// in_tuser: add places a timer at the newest end (or reports the table
// full), delete marks every slot whose key matches and reports the count,
// tick walks the slots newest first, reports one item per timer whose
// elapsed time has reached its timeout, restamps periodic timers, marks
// one-shot ones, and then squeezes out the slots that were marked before
// the tick, keeping age order. A tick with nothing due gives one "nothing
// fired" item; out_tlast marks the final item of each input item, and
// operation code three gives no item at all. One input item is worked at
// a time: the sequencer visits one slot per cycle through a single shared
// compare unit, except that a tick stalls at a due timer while a fired
// key is held and the output register waits on out_tready. The output
// register lets the next item be accepted while the previous result
// still waits. Slot contents are not cleared by reset; only slots below
// the in-use count are ever used.

module oneshot_periodic_timer_table (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // timer_key[15:0], timeout_seconds[46:16],
                                  // repeat_req[47], now_seconds[79:48]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // fired_key[15:0], matched_count[20:16], zero pad
  output logic [2:0]  out_tuser,  // result_kind[2:0]
  output logic        out_tlast
);
  import optt_pkg::*;

  // slot array, one write port, one read port
  entry_t tbl_r [SLOTS];
  logic             tbl_we;
  logic [IDX_W-1:0] tbl_wa;
  entry_t           tbl_wd;
  logic [IDX_W-1:0] tbl_ra;
  entry_t           rd_ent;

  // sequencer
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;    // walk position
  logic [CNT_W-1:0] wr_r, wr_nxt;      // compaction write position
  logic [CNT_W-1:0] used_r, used_nxt;  // slots in use
  logic [CNT_W-1:0] hits_r, hits_nxt;  // delete matches
  logic [SLOTS-1:0] drop_r, drop_nxt;  // slots to squeeze out after a tick

  // latched input item
  logic [KEY_W-1:0]  key_r;
  logic [TMO_W-1:0]  tmo_r;
  logic              rep_r;
  logic [TIME_W-1:0] now_r;

  // fired key held until we know whether it is the final one
  logic             hold_v_r, hold_v_nxt;
  logic [KEY_W-1:0] hold_key_r, hold_key_nxt;

  // output register
  logic              out_v_r, out_v_nxt;
  logic [2:0]        out_kind_r, out_kind_nxt;
  logic [KEY_W-1:0]  out_key_r, out_key_nxt;
  logic [MCNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic              out_last_r, out_last_nxt;

  logic             in_acc;
  logic             out_free;
  logic [IDX_W-1:0] fire_idx;
  verdict_t         verdict;
  entry_t           upd;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_v_r || out_tready;
  assign fire_idx = IDX_W'(idx_r - CNT_W'(1));

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_cnt_r, out_key_r};

  // read side of the slot array
  assign tbl_ra = (state_r == ST_FIRE) ? fire_idx : idx_r[IDX_W-1:0];
  assign rd_ent = tbl_r[tbl_ra];

  optt_unit u_unit (
    .ent     (rd_ent),
    .now     (now_r),
    .key     (key_r),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_r[tbl_wa] <= tbl_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r <= in_tdata[15:0];
      tmo_r <= in_tdata[46:16];
      rep_r <= in_tdata[47];
      now_r <= in_tdata[79:48];
    end
    idx_r      <= idx_nxt;
    wr_r       <= wr_nxt;
    hits_r     <= hits_nxt;
    drop_r     <= drop_nxt;
    hold_key_r <= hold_key_nxt;
    out_kind_r <= out_kind_nxt;
    out_key_r  <= out_key_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      used_r   <= '0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    wr_nxt       = wr_r;
    used_nxt     = used_r;
    hits_nxt     = hits_r;
    drop_nxt     = drop_r;
    hold_v_nxt   = hold_v_r;
    hold_key_nxt = hold_key_r;
    out_v_nxt    = out_v_r && !out_tready;
    out_kind_nxt = out_kind_r;
    out_key_nxt  = out_key_r;
    out_cnt_nxt  = out_cnt_r;
    out_last_nxt = out_last_r;
    tbl_we       = 1'b0;
    tbl_wa       = idx_r[IDX_W-1:0];
    tbl_wd       = rd_ent;
    upd          = rd_ent;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          hits_nxt = '0;
          case (in_tuser)
            OP_ADD: begin
              state_nxt = ST_ADD;
            end
            OP_DEL: begin
              idx_nxt   = '0;
              state_nxt = ST_DEL;
            end
            OP_TICK: begin
              // start at the newest slot
              idx_nxt    = used_r;
              drop_nxt   = '0;
              hold_v_nxt = 1'b0;
              state_nxt  = ST_FIRE;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_ADD: begin
        if (out_free) begin
          out_v_nxt    = 1'b1;
          out_key_nxt  = '0;
          out_cnt_nxt  = '0;
          out_last_nxt = 1'b1;
          if (used_r >= CNT_W'(SLOTS)) begin
            out_kind_nxt = KIND_FULL;
          end else begin
            out_kind_nxt      = KIND_ADDED;
            tbl_we            = 1'b1;
            tbl_wa            = used_r[IDX_W-1:0];
            tbl_wd.key        = key_r;
            tbl_wd.timeout    = tmo_r;
            tbl_wd.last_fired = now_r;
            tbl_wd.repeat_en  = rep_r;
            tbl_wd.marked     = 1'b0;
            used_nxt          = used_r + CNT_W'(1);
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_DEL: begin
        if (idx_r != used_r) begin
          if (verdict.key_hit) begin
            tbl_we        = 1'b1;
            tbl_wd.marked = 1'b1;
            hits_nxt      = hits_r + CNT_W'(1);
          end
          idx_nxt = idx_r + CNT_W'(1);
        end else if (out_free) begin
          out_v_nxt    = 1'b1;
          out_kind_nxt = KIND_DELETED;
          out_key_nxt  = '0;
          out_cnt_nxt  = MCNT_W'(hits_r);
          out_last_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end

      ST_FIRE: begin
        if (idx_r == '0) begin
          state_nxt = ST_FLUSH;
        end else if (rd_ent.marked) begin
          // marked before this tick, squeezed out below
          drop_nxt[fire_idx] = 1'b1;
          idx_nxt            = idx_r - CNT_W'(1);
        end else if (!verdict.expired) begin
          idx_nxt = idx_r - CNT_W'(1);
        end else if (!hold_v_r || out_free) begin
          // a new firing proves the held one is not the final result
          if (hold_v_r) begin
            out_v_nxt    = 1'b1;
            out_kind_nxt = KIND_FIRED;
            out_key_nxt  = hold_key_r;
            out_cnt_nxt  = '0;
            out_last_nxt = 1'b0;
          end
          hold_v_nxt   = 1'b1;
          hold_key_nxt = rd_ent.key;
          if (rd_ent.repeat_en) begin
            upd.last_fired = now_r;
          end else begin
            upd.marked = 1'b1;
          end
          tbl_we  = 1'b1;
          tbl_wa  = fire_idx;
          tbl_wd  = upd;
          idx_nxt = idx_r - CNT_W'(1);
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_v_nxt    = 1'b1;
          out_kind_nxt = hold_v_r ? KIND_FIRED : KIND_QUIET;
          out_key_nxt  = hold_v_r ? hold_key_r : '0;
          out_cnt_nxt  = '0;
          out_last_nxt = 1'b1;
          hold_v_nxt   = 1'b0;
          idx_nxt      = '0;
          wr_nxt       = '0;
          state_nxt    = ST_PACK;
        end
      end

      ST_PACK: begin
        // oldest first, copying each kept slot down to the write position
        if (idx_r == used_r) begin
          used_nxt  = wr_r;
          state_nxt = ST_IDLE;
        end else begin
          if (!drop_r[idx_r[IDX_W-1:0]]) begin
            tbl_we = 1'b1;
            tbl_wa = wr_r[IDX_W-1:0];
            tbl_wd = rd_ent;
            wr_nxt = wr_r + CNT_W'(1);
          end
          idx_nxt = idx_r + CNT_W'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/optt_unit.sv -----
// optt_unit: shared compare unit, one table slot per cycle
// wrap-safe elapsed-time check and key match; depends on optt_pkg
`default_nettype none

module optt_unit (
  input  optt_pkg::entry_t                 ent,
  input  logic [optt_pkg::TIME_W-1:0]      now,
  input  logic [optt_pkg::KEY_W-1:0]       key,
  output optt_pkg::verdict_t               verdict
);
  import optt_pkg::*;

  logic [TIME_W-1:0] elapsed;

  always_comb begin
    // modulo 2^32 difference, so a wrapped clock still counts forward
    elapsed         = now - ent.last_fired;
    verdict.expired = (elapsed >= {1'b0, ent.timeout});
    verdict.key_hit = (ent.key == key);
  end

endmodule

`default_nettype wire
